@@ rtl/rco_pkg.sv @@
// Shared types, widths and helper functions for the rotated checker overlay.
// Used by the channel interfaces and by every module of the block.
package rco_pkg;

  localparam int PIX_W      = 10;
  localparam int IDX_W      = 8;
  localparam int ANG_W      = 16;
  localparam int CELL_W     = 8;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DX_W   = PIX_W + 2;
  localparam int PROD_W = DX_W + ANG_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int FRAC_BITS_DEF = 14;

  localparam logic [ANG_W-1:0]  COS_RESET   = 16'd16384;
  localparam logic [ANG_W-1:0]  SIN_RESET   = 16'd0;
  localparam logic [CELL_W-1:0] CELL_RESET  = 8'd24;
  localparam logic [DIM_W-1:0]  WIDTH_RESET = 11'd320;
  localparam logic [DIM_W-1:0]  HEIGHT_RESET = 11'd200;
  localparam logic [IDX_W-1:0]  LIGHT_RESET = 8'd74;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COS    = 3'd0,
    CFG_SIN    = 3'd1,
    CFG_CELL   = 3'd2,
    CFG_WIDTH  = 3'd3,
    CFG_HEIGHT = 3'd4,
    CFG_LIGHT  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ANG_W-1:0]  cos_angle;
    logic [ANG_W-1:0]  sin_angle;
    logic [CELL_W-1:0] cell_size;
    logic [DIM_W-1:0]  screen_width;
    logic [DIM_W-1:0]  screen_height;
    logic [IDX_W-1:0]  light_offset;
  } cfg_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [CELL_W:0] div_step(input logic [CELL_W-1:0] rem,
                                               input logic              din,
                                               input logic [CELL_W-1:0] dvs);
    logic [CELL_W:0] trial;
    logic [CELL_W:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      div_step = {1'b1, diff[CELL_W-1:0]};
    end else begin
      div_step = {1'b0, trial[CELL_W-1:0]};
    end
  endfunction

endpackage

@@ rtl/rco_if.sv @@
// Valid/ready channel interfaces for pixel beats, result beats and register writes.
// Depends on rco_pkg for field widths.
interface rco_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rco_pkg::PIX_W-1:0]  pixel_x;
  logic [rco_pkg::PIX_W-1:0]  pixel_y;
  logic [rco_pkg::IDX_W-1:0]  index_in;
  modport source(output valid, pixel_x, pixel_y, index_in, input ready);
  modport sink(input valid, pixel_x, pixel_y, index_in, output ready);
endinterface

interface rco_res_if;
  logic                       valid;
  logic                       ready;
  logic [rco_pkg::IDX_W-1:0]  index_out;
  logic                       on_light_cell;
  modport source(output valid, index_out, on_light_cell, input ready);
  modport sink(input valid, index_out, on_light_cell, output ready);
endinterface

interface rco_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rco_pkg::CFG_IDX_W-1:0]   index;
  logic [rco_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/rco_cfg_regs.sv @@
// Configuration register file for the overlay, written one beat at a time.
// Depends on rco_pkg for the register codes and the cfg_t struct.
module rco_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_valid,
  output logic                           wr_ready,
  input  logic [rco_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [rco_pkg::CFG_DATA_W-1:0] wr_data,
  output rco_pkg::cfg_t                  cfg
);

  rco_pkg::cfg_t cfg_next;

  assign wr_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (wr_valid) begin
      unique case (wr_index)
        rco_pkg::CFG_COS:    cfg_next.cos_angle     = wr_data;
        rco_pkg::CFG_SIN:    cfg_next.sin_angle     = wr_data;
        rco_pkg::CFG_CELL:   cfg_next.cell_size     = wr_data[rco_pkg::CELL_W-1:0];
        rco_pkg::CFG_WIDTH:  cfg_next.screen_width  = wr_data[rco_pkg::DIM_W-1:0];
        rco_pkg::CFG_HEIGHT: cfg_next.screen_height = wr_data[rco_pkg::DIM_W-1:0];
        rco_pkg::CFG_LIGHT:  cfg_next.light_offset  = wr_data[rco_pkg::IDX_W-1:0];
        default:             cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_angle     <= rco_pkg::COS_RESET;
      cfg.sin_angle     <= rco_pkg::SIN_RESET;
      cfg.cell_size     <= rco_pkg::CELL_RESET;
      cfg.screen_width  <= rco_pkg::WIDTH_RESET;
      cfg.screen_height <= rco_pkg::HEIGHT_RESET;
      cfg.light_offset  <= rco_pkg::LIGHT_RESET;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

@@ rtl/rco_rotate.sv @@
// Three-stage front end: center offset, rotation products, sums and scaling.
// Produces the magnitude and sign of each coarse coordinate; depends on rco_pkg.
module rco_rotate #(
  parameter int FRAC_BITS = rco_pkg::FRAC_BITS_DEF,
  localparam int Q_W = rco_pkg::SUM_W - FRAC_BITS - 1,
  localparam int M_W = Q_W - 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        in_valid,
  input  logic [rco_pkg::PIX_W-1:0]   pixel_x,
  input  logic [rco_pkg::PIX_W-1:0]   pixel_y,
  input  logic [rco_pkg::IDX_W-1:0]   index_in,
  input  rco_pkg::cfg_t               cfg,
  output logic                        out_valid,
  output logic [M_W-1:0]              mag_u,
  output logic                        neg_u,
  output logic [M_W-1:0]              mag_v,
  output logic                        neg_v,
  output logic [rco_pkg::IDX_W-1:0]   index_out
);

  localparam int DX_W   = rco_pkg::DX_W;
  localparam int PROD_W = rco_pkg::PROD_W;
  localparam int SUM_W  = rco_pkg::SUM_W;

  logic                        v1;
  logic signed [DX_W-1:0]      dx;
  logic signed [DX_W-1:0]      dy;
  logic [rco_pkg::IDX_W-1:0]   idx1;

  logic                        v2;
  logic signed [PROD_W-1:0]    p_xc;
  logic signed [PROD_W-1:0]    p_ys;
  logic signed [PROD_W-1:0]    p_xs;
  logic signed [PROD_W-1:0]    p_yc;
  logic [rco_pkg::IDX_W-1:0]   idx2;

  logic signed [SUM_W-1:0]     sum_u;
  logic signed [SUM_W-1:0]     sum_v;
  logic [Q_W-1:0]              q_u;
  logic [Q_W-1:0]              q_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx   <= $signed({1'b0, pixel_x, 1'b1}) - $signed({1'b0, cfg.screen_width});
      dy   <= $signed({1'b0, pixel_y, 1'b1}) - $signed({1'b0, cfg.screen_height});
      idx1 <= index_in;

      p_xc <= PROD_W'(dx * $signed(cfg.cos_angle));
      p_ys <= PROD_W'(dy * $signed(cfg.sin_angle));
      p_xs <= PROD_W'(dx * $signed(cfg.sin_angle));
      p_yc <= PROD_W'(dy * $signed(cfg.cos_angle));
      idx2 <= idx1;

      neg_u     <= q_u[Q_W-1];
      mag_u     <= q_u[Q_W-1] ? ~q_u[M_W-1:0] : q_u[M_W-1:0];
      neg_v     <= q_v[Q_W-1];
      mag_v     <= q_v[Q_W-1] ? ~q_v[M_W-1:0] : q_v[M_W-1:0];
      index_out <= idx2;
    end
  end

  always_comb begin
    sum_u = $signed({p_xc[PROD_W-1], p_xc}) - $signed({p_ys[PROD_W-1], p_ys});
    sum_v = $signed({p_xs[PROD_W-1], p_xs}) + $signed({p_yc[PROD_W-1], p_yc});
    q_u   = sum_u[SUM_W-1:FRAC_BITS+1];
    q_v   = sum_v[SUM_W-1:FRAC_BITS+1];
  end

endmodule

@@ rtl/rco_div_pipe.sv @@
// Pipelined restoring division of both coarse coordinates by the cell size.
// One quotient bit per stage and lane; only the final quotient bit is kept. Uses rco_pkg.
module rco_div_pipe #(
  parameter int M_W = 12
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [rco_pkg::CELL_W-1:0]  cell_size,
  input  logic                        in_valid,
  input  logic [M_W-1:0]              mag_u,
  input  logic                        neg_u,
  input  logic [M_W-1:0]              mag_v,
  input  logic                        neg_v,
  input  logic [rco_pkg::IDX_W-1:0]   index_in,
  output logic                        out_valid,
  output logic                        parity,
  output logic [rco_pkg::IDX_W-1:0]   index_out
);

  localparam int CW = rco_pkg::CELL_W;

  logic [CW-1:0] dvs;

  logic                       vld  [M_W+1];
  logic [M_W-1:0]             mu   [M_W+1];
  logic [M_W-1:0]             mv   [M_W+1];
  logic                       nu   [M_W+1];
  logic                       nv   [M_W+1];
  logic [CW-1:0]              ru   [M_W+1];
  logic [CW-1:0]              rv   [M_W+1];
  logic                       qu   [M_W+1];
  logic                       qv   [M_W+1];
  logic [rco_pkg::IDX_W-1:0]  idx  [M_W+1];

  // A zero cell size behaves as a cell of one pixel.
  assign dvs = (cell_size == '0) ? CW'(1) : cell_size;

  assign vld[0] = in_valid;
  assign mu[0]  = mag_u;
  assign mv[0]  = mag_v;
  assign nu[0]  = neg_u;
  assign nv[0]  = neg_v;
  assign ru[0]  = '0;
  assign rv[0]  = '0;
  assign qu[0]  = 1'b0;
  assign qv[0]  = 1'b0;
  assign idx[0] = index_in;

  for (genvar k = 0; k < M_W; k++) begin : g_stage
    logic [CW:0] step_u;
    logic [CW:0] step_v;

    assign step_u = rco_pkg::div_step(ru[k], mu[k][M_W-1-k], dvs);
    assign step_v = rco_pkg::div_step(rv[k], mv[k][M_W-1-k], dvs);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mu[k+1]  <= mu[k];
        mv[k+1]  <= mv[k];
        nu[k+1]  <= nu[k];
        nv[k+1]  <= nv[k];
        ru[k+1]  <= step_u[CW-1:0];
        rv[k+1]  <= step_v[CW-1:0];
        qu[k+1]  <= step_u[CW];
        qv[k+1]  <= step_v[CW];
        idx[k+1] <= idx[k];
      end
    end
  end

  // For a negative coordinate the quotient of its complement flips the low bit.
  assign out_valid = vld[M_W];
  assign parity    = qu[M_W] ^ nu[M_W] ^ qv[M_W] ^ nv[M_W];
  assign index_out = idx[M_W];

endmodule

@@ rtl/rotated_checker_overlay_top.sv @@
// Top level of the rotated checker overlay: register file, rotation front end,
// cell divider pipeline and output register. Depends on rco_pkg and rco_if.
//
//   Channel  Dir  Beat payload
//   pix      in   pixel_x, pixel_y, index_in
//   res      out  index_out, on_light_cell
//   cfg      in   index, data (register write)
//
// One pixel beat is taken every cycle while the result side drains. A beat passes
// through the rotation front end, then the divider pipeline that produces one
// quotient bit per stage, then the output register. A stalled result holds the
// whole pipeline in place. Reset is synchronous and clears all valid bits and
// restores the register defaults.
module rotated_checker_overlay_top #(
  parameter int FRAC_BITS = rco_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rco_pix_if.sink     pix,
  rco_res_if.source   res,
  rco_cfg_if.sink     cfg
);

  localparam int Q_W = rco_pkg::SUM_W - FRAC_BITS - 1;
  localparam int M_W = Q_W - 1;

  rco_pkg::cfg_t              cfg_q;
  logic                       adv;

  logic                       rot_valid;
  logic [M_W-1:0]             rot_mag_u;
  logic                       rot_neg_u;
  logic [M_W-1:0]             rot_mag_v;
  logic                       rot_neg_v;
  logic [rco_pkg::IDX_W-1:0]  rot_idx;

  logic                       div_valid;
  logic                       div_parity;
  logic [rco_pkg::IDX_W-1:0]  div_idx;

  logic                       res_valid;
  logic [rco_pkg::IDX_W-1:0]  res_index;
  logic                       res_light;

  assign adv       = !res_valid || res.ready;
  assign pix.ready = adv;

  rco_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  rco_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pix.valid),
    .pixel_x   (pix.pixel_x),
    .pixel_y   (pix.pixel_y),
    .index_in  (pix.index_in),
    .cfg       (cfg_q),
    .out_valid (rot_valid),
    .mag_u     (rot_mag_u),
    .neg_u     (rot_neg_u),
    .mag_v     (rot_mag_v),
    .neg_v     (rot_neg_v),
    .index_out (rot_idx)
  );

  rco_div_pipe #(
    .M_W (M_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cell_size (cfg_q.cell_size),
    .in_valid  (rot_valid),
    .mag_u     (rot_mag_u),
    .neg_u     (rot_neg_u),
    .mag_v     (rot_mag_v),
    .neg_v     (rot_neg_v),
    .index_in  (rot_idx),
    .out_valid (div_valid),
    .parity    (div_parity),
    .index_out (div_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_light <= div_parity;
      res_index <= div_parity ? rco_pkg::IDX_W'(div_idx + cfg_q.light_offset) : div_idx;
    end
  end

  assign res.valid         = res_valid;
  assign res.index_out     = res_index;
  assign res.on_light_cell = res_light;

`ifndef NO_ASSERTIONS
  a_div_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(div_valid))
    else $error("divider pipeline moved while the result beat was stalled");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !res.valid)
    else $error("result beat valid after reset");

  a_pix_ready_tracks_drain: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !pix.ready)
    else $error("pixel beat taken while the pipeline is stalled");
`endif

endmodule
